>>> rtl/pbmt_pkg.sv
// shared widths, types and helpers for the position bounds and mean tracker
// no dependencies
package pbmt_pkg;

  localparam int LAT_W       = 28;
  localparam int LON_W       = 29;
  localparam int ALT_W       = 38;
  localparam int FIX_W       = 2;
  localparam int SUM_W       = 62;
  localparam int CNT_W       = 61;
  localparam int RESCALE_BIT = 60;
  localparam int DIV_STEPS   = SUM_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [FIX_W-1:0] FIX_2D = FIX_W'(2);

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic        [CNT_W-1:0] cnt_t;

  localparam sum_t SUM_LIM = sum_t'(1) <<< RESCALE_BIT;
  localparam cnt_t CNT_LIM = cnt_t'(1) << RESCALE_BIT;

  function automatic logic sum_too_big(sum_t s);
    sum_too_big = (s >= SUM_LIM) || (s <= -SUM_LIM);
  endfunction

endpackage

>>> rtl/pbmt_div.sv
// bit-serial restoring divider: signed sum over unsigned count, truncated toward zero
// one quotient bit per cycle; a zero divisor gives a zero quotient
// depends on pbmt_pkg
module pbmt_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  pbmt_pkg::sum_t dividend,
  input  pbmt_pkg::cnt_t divisor,
  output logic           done,
  output pbmt_pkg::sum_t quotient
);
  import pbmt_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;
  cnt_t              dvs;
  logic              neg;

  logic [SUM_W:0]    trial;
  logic              fits;
  logic [SUM_W-1:0]  rem_next;
  logic [SUM_W-1:0]  quo_next;
  logic [SUM_W-1:0]  mag;

  assign mag      = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign trial    = {rem, quo[SUM_W-1]};
  assign fits     = trial >= (SUM_W+1)'(dvs);
  assign rem_next = fits ? SUM_W'(trial - (SUM_W+1)'(dvs)) : trial[SUM_W-1:0];
  assign quo_next = {quo[SUM_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        done <= (divisor == '0);
        if (divisor == '0) begin
          quotient <= '0;
        end else begin
          busy <= 1'b1;
          rem  <= '0;
          quo  <= mag;
          dvs  <= divisor;
          neg  <= dividend[SUM_W-1];
          step <= '0;
        end
      end else if (busy) begin
        rem  <= rem_next;
        quo  <= quo_next;
        step <= step + STEP_W'(1);
        done <= (step == STEP_W'(DIV_STEPS - 1));
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy     <= 1'b0;
          quotient <= neg ? sum_t'(-quo_next) : sum_t'(quo_next);
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/position_bounds_and_mean_tracker.sv
// top level: bounding box, best fix and running means of position fixes
// depends on pbmt_pkg and pbmt_div
//
// One item is worked at a time. Three quotients (latitude, longitude, altitude mean)
// go one after the other through a single bit-serial divider that yields one
// quotient bit per cycle, 62 bits each; per quotient a GO state starts the divider
// and a WAIT state takes the quotient, and the FINISH state then loads the output
// register once it is free. While no altitude has been summed the altitude divisor
// is zero and the divider gives a zero quotient without stepping through the bits.
// The next item is taken as soon as the result sits in the output register, even
// while it still waits to be taken. Bounds that read zero count as unset.
module position_bounds_and_mean_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pbmt_pkg::LAT_W-1:0]   latitude,
  input  logic signed [pbmt_pkg::LON_W-1:0]   longitude,
  input  logic signed [pbmt_pkg::ALT_W-1:0]   altitude,
  input  logic        [pbmt_pkg::FIX_W-1:0]   fix_quality,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [pbmt_pkg::FIX_W-1:0]   best_fix,
  output logic signed [pbmt_pkg::LAT_W-1:0]   min_latitude,
  output logic signed [pbmt_pkg::LAT_W-1:0]   max_latitude,
  output logic signed [pbmt_pkg::LON_W-1:0]   min_longitude,
  output logic signed [pbmt_pkg::LON_W-1:0]   max_longitude,
  output logic signed [pbmt_pkg::ALT_W-1:0]   min_altitude,
  output logic signed [pbmt_pkg::ALT_W-1:0]   max_altitude,
  output logic signed [pbmt_pkg::LAT_W-1:0]   mean_latitude,
  output logic signed [pbmt_pkg::LON_W-1:0]   mean_longitude,
  output logic signed [pbmt_pkg::ALT_W-1:0]   mean_altitude
);
  import pbmt_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LAT_GO   = 3'd1;
  localparam logic [2:0] S_LAT_WAIT = 3'd2;
  localparam logic [2:0] S_LON_GO   = 3'd3;
  localparam logic [2:0] S_LON_WAIT = 3'd4;
  localparam logic [2:0] S_ALT_GO   = 3'd5;
  localparam logic [2:0] S_ALT_WAIT = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  logic [2:0] state;

  logic [FIX_W-1:0]        fix_best;
  logic signed [LAT_W-1:0] lat_low, lat_high;
  logic signed [LON_W-1:0] lon_low, lon_high;
  logic signed [ALT_W-1:0] alt_low, alt_high;
  sum_t lat_sum, lon_sum, alt_sum;
  cnt_t sample_count, alt_count;
  sum_t mlat, mlon, malt;

  logic has_alt;
  logic accept;
  logic rescale;
  logic load_out;

  logic div_start;
  sum_t div_dividend;
  cnt_t div_divisor;
  logic div_done;
  sum_t div_quotient;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign has_alt  = fix_quality > FIX_2D;
  assign load_out = (state == S_FINISH) && (!out_valid || out_ready);
  assign rescale  = sum_too_big(lat_sum) || sum_too_big(lon_sum) || sum_too_big(alt_sum) ||
                    (sample_count >= CNT_LIM) || (alt_count >= CNT_LIM);

  always_comb begin
    div_start = state inside {S_LAT_GO, S_LON_GO, S_ALT_GO};
    case (state)
      S_LAT_GO: begin
        div_dividend = lat_sum;
        div_divisor  = sample_count;
      end
      S_LON_GO: begin
        div_dividend = lon_sum;
        div_divisor  = sample_count;
      end
      default: begin
        div_dividend = alt_sum;
        div_divisor  = alt_count;
      end
    endcase
  end

  pbmt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      fix_best     <= '0;
      lat_low      <= '0;
      lat_high     <= '0;
      lon_low      <= '0;
      lon_high     <= '0;
      alt_low      <= '0;
      alt_high     <= '0;
      lat_sum      <= '0;
      lon_sum      <= '0;
      alt_sum      <= '0;
      sample_count <= '0;
      alt_count    <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (fix_quality > fix_best) begin
              fix_best <= fix_quality;
            end
            if (latitude < lat_low || lat_low == '0) begin
              lat_low <= latitude;
            end
            if (latitude > lat_high || lat_high == '0) begin
              lat_high <= latitude;
            end
            if (longitude < lon_low || lon_low == '0) begin
              lon_low <= longitude;
            end
            if (longitude > lon_high || lon_high == '0) begin
              lon_high <= longitude;
            end
            lat_sum      <= lat_sum + sum_t'(latitude);
            lon_sum      <= lon_sum + sum_t'(longitude);
            sample_count <= sample_count + cnt_t'(1);
            if (has_alt) begin
              if (altitude < alt_low || alt_low == '0) begin
                alt_low <= altitude;
              end
              if (altitude > alt_high || alt_high == '0) begin
                alt_high <= altitude;
              end
              alt_sum   <= alt_sum + sum_t'(altitude);
              alt_count <= alt_count + cnt_t'(1);
            end
            state <= S_LAT_GO;
          end
        end
        S_LAT_GO: state <= S_LAT_WAIT;
        S_LAT_WAIT: begin
          if (div_done) begin
            mlat  <= div_quotient;
            state <= S_LON_GO;
          end
        end
        S_LON_GO: state <= S_LON_WAIT;
        S_LON_WAIT: begin
          if (div_done) begin
            mlon  <= div_quotient;
            state <= S_ALT_GO;
          end
        end
        S_ALT_GO: state <= S_ALT_WAIT;
        S_ALT_WAIT: begin
          if (div_done) begin
            malt  <= div_quotient;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load_out) begin
            state <= S_IDLE;
            // sums fold into their means once any magnitude grows too large
            if (rescale) begin
              lat_sum      <= mlat;
              lon_sum      <= mlon;
              alt_sum      <= malt;
              sample_count <= cnt_t'(1);
              alt_count    <= cnt_t'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload, held while waiting to be taken
  always_ff @(posedge clk) begin
    if (load_out) begin
      best_fix       <= fix_best;
      min_latitude   <= lat_low;
      max_latitude   <= lat_high;
      min_longitude  <= lon_low;
      max_longitude  <= lon_high;
      min_altitude   <= alt_low;
      max_altitude   <= alt_high;
      mean_latitude  <= mlat[LAT_W-1:0];
      mean_longitude <= mlon[LON_W-1:0];
      mean_altitude  <= malt[ALT_W-1:0];
    end
  end

endmodule

>>> tb/fix_tracker_checker.sv
`timescale 1ns / 100ps
// checker for the position bounds and mean tracker: watches both channels, predicts
// each summary from the accepted fixes and compares it field by field; uses pbmt_pkg
module fix_tracker_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [pbmt_pkg::LAT_W-1:0]   latitude,
  input  logic signed [pbmt_pkg::LON_W-1:0]   longitude,
  input  logic signed [pbmt_pkg::ALT_W-1:0]   altitude,
  input  logic        [pbmt_pkg::FIX_W-1:0]   fix_quality,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic        [pbmt_pkg::FIX_W-1:0]   best_fix,
  input  logic signed [pbmt_pkg::LAT_W-1:0]   min_latitude,
  input  logic signed [pbmt_pkg::LAT_W-1:0]   max_latitude,
  input  logic signed [pbmt_pkg::LON_W-1:0]   min_longitude,
  input  logic signed [pbmt_pkg::LON_W-1:0]   max_longitude,
  input  logic signed [pbmt_pkg::ALT_W-1:0]   min_altitude,
  input  logic signed [pbmt_pkg::ALT_W-1:0]   max_altitude,
  input  logic signed [pbmt_pkg::LAT_W-1:0]   mean_latitude,
  input  logic signed [pbmt_pkg::LON_W-1:0]   mean_longitude,
  input  logic signed [pbmt_pkg::ALT_W-1:0]   mean_altitude,
  output int                                  mismatches,
  output int                                  pending
);
  import pbmt_pkg::*;

  localparam sum_t ACC_BOUND = sum_t'(1) <<< RESCALE_BIT;
  localparam cnt_t CNT_BOUND = cnt_t'(1) << RESCALE_BIT;

  typedef struct {
    logic        [FIX_W-1:0] best;
    logic signed [LAT_W-1:0] lat_min;
    logic signed [LAT_W-1:0] lat_max;
    logic signed [LON_W-1:0] lon_min;
    logic signed [LON_W-1:0] lon_max;
    logic signed [ALT_W-1:0] alt_min;
    logic signed [ALT_W-1:0] alt_max;
    logic signed [LAT_W-1:0] lat_mean;
    logic signed [LON_W-1:0] lon_mean;
    logic signed [ALT_W-1:0] alt_mean;
  } fix_summary_t;

  fix_summary_t expected_summaries[$];

  logic        [FIX_W-1:0] best_seen;
  logic signed [LAT_W-1:0] lat_lo, lat_hi;
  logic signed [LON_W-1:0] lon_lo, lon_hi;
  logic signed [ALT_W-1:0] alt_lo, alt_hi;
  sum_t                    lat_acc, lon_acc, alt_acc;
  cnt_t                    fix_n, alt_n;

  int mismatch_count = 0;
  int waiting = 0;
  int result_no = 0;

  assign mismatches = mismatch_count;
  assign pending    = waiting;

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic signed [63:0] got, logic signed [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d", result_no, name, got,
                                want));
  endtask

  function automatic logic acc_too_big(sum_t s);
    return (s >= ACC_BOUND) || (s <= -ACC_BOUND);
  endfunction

  task automatic track_fix(input logic signed [LAT_W-1:0] lat,
                           input logic signed [LON_W-1:0] lon,
                           input logic signed [ALT_W-1:0] alt,
                           input logic [FIX_W-1:0] fix,
                           output fix_summary_t r);
    sum_t q_lat, q_lon, q_alt;
    logic has_alt;
    has_alt = fix > FIX_2D;
    if (fix > best_seen) best_seen = fix;

    // a stored bound of zero reads as unset
    if (lat < lat_lo || lat_lo == '0) lat_lo = lat;
    if (lat > lat_hi || lat_hi == '0) lat_hi = lat;
    if (lon < lon_lo || lon_lo == '0) lon_lo = lon;
    if (lon > lon_hi || lon_hi == '0) lon_hi = lon;
    if (has_alt) begin
      if (alt < alt_lo || alt_lo == '0) alt_lo = alt;
      if (alt > alt_hi || alt_hi == '0) alt_hi = alt;
    end

    lat_acc = lat_acc + sum_t'(lat);
    lon_acc = lon_acc + sum_t'(lon);
    fix_n   = fix_n + cnt_t'(1);
    if (has_alt) begin
      alt_acc = alt_acc + sum_t'(alt);
      alt_n   = alt_n + cnt_t'(1);
    end

    q_lat = lat_acc / sum_t'({1'b0, fix_n});
    q_lon = lon_acc / sum_t'({1'b0, fix_n});
    q_alt = (alt_n != '0) ? alt_acc / sum_t'({1'b0, alt_n}) : sum_t'(0);

    r.best     = best_seen;
    r.lat_min  = lat_lo;
    r.lat_max  = lat_hi;
    r.lon_min  = lon_lo;
    r.lon_max  = lon_hi;
    r.alt_min  = alt_lo;
    r.alt_max  = alt_hi;
    r.lat_mean = q_lat[LAT_W-1:0];
    r.lon_mean = q_lon[LON_W-1:0];
    r.alt_mean = q_alt[ALT_W-1:0];

    // fold sums into their means once anything gets near the top
    if (acc_too_big(lat_acc) || acc_too_big(lon_acc) || acc_too_big(alt_acc) ||
        fix_n >= CNT_BOUND || alt_n >= CNT_BOUND) begin
      lat_acc = q_lat;
      lon_acc = q_lon;
      alt_acc = q_alt;
      fix_n   = cnt_t'(1);
      alt_n   = cnt_t'(1);
    end
  endtask

  always @(posedge clk) begin : watch
    fix_summary_t want;
    if (rst) begin
      best_seen = '0;
      lat_lo = '0;
      lat_hi = '0;
      lon_lo = '0;
      lon_hi = '0;
      alt_lo = '0;
      alt_hi = '0;
      lat_acc = '0;
      lon_acc = '0;
      alt_acc = '0;
      fix_n = '0;
      alt_n = '0;
      expected_summaries.delete();
    end else begin
      if (out_valid && out_ready) begin
        result_no++;
        if (expected_summaries.size() == 0) begin
          report_mismatch($sformatf("result %0d with no item waiting", result_no));
        end else begin
          want = expected_summaries.pop_front();
          check_field("best_fix", best_fix, want.best);
          check_field("min_latitude", min_latitude, want.lat_min);
          check_field("max_latitude", max_latitude, want.lat_max);
          check_field("min_longitude", min_longitude, want.lon_min);
          check_field("max_longitude", max_longitude, want.lon_max);
          check_field("min_altitude", min_altitude, want.alt_min);
          check_field("max_altitude", max_altitude, want.alt_max);
          check_field("mean_latitude", mean_latitude, want.lat_mean);
          check_field("mean_longitude", mean_longitude, want.lon_mean);
          check_field("mean_altitude", mean_altitude, want.alt_mean);
        end
      end
      if (in_valid && in_ready) begin
        track_fix(latitude, longitude, altitude, fix_quality, want);
        expected_summaries.insert(expected_summaries.size(), want);
      end
    end
    waiting <= expected_summaries.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// top of the position bounds and mean tracker testbench: clock, reset, fix stimulus
// and result sink; depends on pbmt_pkg, the tracker and fix_tracker_checker
module tb;
  import pbmt_pkg::*;

  localparam int RANDOM_FIXES = 1250;
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT  = 4000000;

  localparam logic [FIX_W-1:0] FIX_NONE    = FIX_W'(0);
  localparam logic [FIX_W-1:0] FIX_UNKNOWN = FIX_W'(1);
  localparam logic [FIX_W-1:0] FIX_3D      = FIX_W'(3);

  localparam logic signed [LAT_W-1:0] LAT_NEG = {1'b1, {(LAT_W-1){1'b0}}};
  localparam logic signed [LON_W-1:0] LON_NEG = {1'b1, {(LON_W-1){1'b0}}};
  localparam logic signed [ALT_W-1:0] ALT_NEG = {1'b1, {(ALT_W-1){1'b0}}};

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [LAT_W-1:0] latitude = '0;
  logic signed [LON_W-1:0] longitude = '0;
  logic signed [ALT_W-1:0] altitude = '0;
  logic        [FIX_W-1:0] fix_quality = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic        [FIX_W-1:0] best_fix;
  logic signed [LAT_W-1:0] min_latitude, max_latitude, mean_latitude;
  logic signed [LON_W-1:0] min_longitude, max_longitude, mean_longitude;
  logic signed [ALT_W-1:0] min_altitude, max_altitude, mean_altitude;

  int mismatches;
  int pending;
  bit no_idle = 1'b0;

  position_bounds_and_mean_tracker dut (.*);

  fix_tracker_checker checker_i (.mismatches(mismatches), .pending(pending), .*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_cycles();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 60);
    return $urandom_range(61, 300);
  endfunction

  function automatic logic signed [63:0] pick_value(longint lo, longint hi, int w);
    int unsigned pick;
    longint unsigned raw, span;
    logic signed [63:0] v;
    pick = $urandom_range(0, 99);
    raw  = {$urandom, $urandom};
    if (pick < 8) begin
      v = 0;
    end else if (pick < 12) begin
      v = lo;
    end else if (pick < 16) begin
      v = hi;
    end else if (pick < 19) begin
      v = -(64'sd1 <<< (w - 1));
    end else if (pick < 22) begin
      v = (64'sd1 <<< (w - 1)) - 1;
    end else if (pick < 32) begin
      v = longint'($urandom_range(0, 20)) - 10;
    end else if (pick < 50) begin
      v = $signed(raw);
      v = (v <<< (64 - w)) >>> (64 - w);
    end else begin
      span = longint'(hi - lo) + 1;
      v = lo + longint'(raw % span);
    end
    return v;
  endfunction

  task automatic send_fix(input logic signed [LAT_W-1:0] lat,
                          input logic signed [LON_W-1:0] lon,
                          input logic signed [ALT_W-1:0] alt,
                          input logic [FIX_W-1:0] fix);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    latitude    <= lat;
    longitude   <= lon;
    altitude    <= alt;
    fix_quality <= fix;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_ready <= 1'b0;
        // sometimes hold off only once the result is already on offer
        if ($urandom_range(0, 1)) begin
          do @(posedge clk); while (!out_valid);
        end
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL position_bounds_and_mean_tracker");
    $finish;
  end

  initial begin : stimulus
    logic [FIX_W-1:0] fix;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zeros into unset bounds, then no altitude yet
    send_fix('0, '0, '0, FIX_NONE);
    send_fix(28'sd12, -29'sd7, 38'sd5, FIX_UNKNOWN);
    send_fix(-28'sd3, 29'sd4, 38'sd100000000000, FIX_2D);
    send_fix(28'sd90000000, 29'sd180000000, 38'sd100000000000, FIX_3D);
    send_fix(-28'sd90000000, -29'sd180000000, -38'sd1000000000, FIX_3D);
    send_fix('0, '0, '0, FIX_3D);
    send_fix(LAT_NEG, LON_NEG, ALT_NEG, FIX_3D);
    send_fix(~LAT_NEG, ~LON_NEG, ~ALT_NEG, FIX_3D);
    send_fix('1, '1, '1, FIX_3D);
    send_fix(~LAT_NEG, ~LON_NEG, ALT_NEG, FIX_2D);
    send_fix(-28'sd1, -29'sd2, -38'sd3, FIX_3D);
    send_fix(-28'sd5, 29'sd3, -38'sd7, FIX_NONE);
    send_fix(28'sd1, -29'sd1, 38'sd1, FIX_UNKNOWN);
    send_fix(28'sd45000000, -29'sd90000000, 38'sd250000000, FIX_3D);

    for (int i = 0; i < RANDOM_FIXES; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      fix = ($urandom_range(0, 9) < 5) ? FIX_3D : FIX_W'($urandom_range(FIX_NONE, FIX_2D));
      send_fix(LAT_W'(pick_value(-90000000, 90000000, LAT_W)),
               LON_W'(pick_value(-180000000, 180000000, LON_W)),
               ALT_W'(pick_value(-1000000000, 100000000000, ALT_W)),
               fix);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("PASS position_bounds_and_mean_tracker");
    end else begin
      $display("FAIL position_bounds_and_mean_tracker");
    end
    $finish;
  end

endmodule

>>> position_bounds_and_mean_tracker.f
rtl/pbmt_pkg.sv
rtl/pbmt_div.sv
rtl/position_bounds_and_mean_tracker.sv
tb/fix_tracker_checker.sv
tb/tb.sv
